FILE: sv/adclin_pkg.sv
`timescale 1ns / 1ps
// Package for the ADC-to-temperature linearizer: sizes, codes, shared types
// and the built-in calibration table. It has no dependencies.
package adclin_pkg;

  localparam int TABLE_POINTS   = 53;
  localparam int SAMPLE_BITS    = 12;
  localparam int ADC_BITS       = 13;
  localparam int TEMP_BITS      = 16;
  localparam int PIDX_BITS      = 6;
  localparam int IDX_BITS       = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
  localparam int NUM_BITS       = TEMP_BITS + SAMPLE_BITS;
  localparam int CMP_BITS       = (ADC_BITS > SAMPLE_BITS) ? ADC_BITS : SAMPLE_BITS;
  localparam int DIV_CNT_BITS   = $clog2(NUM_BITS + 1);
  localparam int BUILTIN_POINTS = 53;
  localparam int BI_BITS        = $clog2(BUILTIN_POINTS);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_POINTS - 1);

  typedef enum logic [0:0] {
    CMD_CONVERT = 1'b0,
    CMD_WRITE   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [ADC_BITS-1:0]  adc;
    logic [TEMP_BITS-1:0] temp;
  } entry_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_status_t;

  localparam logic [ADC_BITS-1:0] INIT_ADC [BUILTIN_POINTS] = '{
    13'd0,    13'd184,  13'd226,  13'd269,  13'd313,  13'd358,  13'd404,  13'd452,
    13'd501,  13'd550,  13'd601,  13'd654,  13'd707,  13'd762,  13'd818,  13'd876,
    13'd935,  13'd995,  13'd1057, 13'd1120, 13'd1184, 13'd1251, 13'd1318, 13'd1388,
    13'd1459, 13'd1531, 13'd1605, 13'd1681, 13'd1759, 13'd1838, 13'd1919, 13'd2002,
    13'd2086, 13'd2173, 13'd2261, 13'd2351, 13'd2443, 13'd2537, 13'd2632, 13'd2730,
    13'd2829, 13'd2931, 13'd3034, 13'd3140, 13'd3247, 13'd3356, 13'd3467, 13'd3580,
    13'd3695, 13'd3812, 13'd3931, 13'd4052, 13'd4096
  };

  localparam logic [TEMP_BITS-1:0] INIT_TEMP [BUILTIN_POINTS] = '{
    16'd4000, 16'd4000, 16'd3940, 16'd3880, 16'd3820, 16'd3760, 16'd3700, 16'd3640,
    16'd3600, 16'd3550, 16'd3510, 16'd3510, 16'd3500, 16'd3490, 16'd3480, 16'd3470,
    16'd3450, 16'd3400, 16'd3350, 16'd3300, 16'd3250, 16'd3200, 16'd3000, 16'd2800,
    16'd2680, 16'd2560, 16'd2450, 16'd2380, 16'd2370, 16'd2369, 16'd2350, 16'd2330,
    16'd2300, 16'd2280, 16'd2270, 16'd2260, 16'd2200, 16'd1840, 16'd1780, 16'd1720,
    16'd1660, 16'd1600, 16'd1540, 16'd1480, 16'd1420, 16'd1360, 16'd1300, 16'd1240,
    16'd1180, 16'd1120, 16'd1060, 16'd1000, 16'd1000
  };

  // Reset value of a table entry; entries past the built-in table repeat its last point.
  function automatic entry_t init_entry(input logic [IDX_BITS-1:0] idx);
    logic [BI_BITS-1:0] k;
    entry_t             e;
    k = (int'(idx) < BUILTIN_POINTS) ? BI_BITS'(idx) : BI_BITS'(BUILTIN_POINTS - 1);
    e.adc  = INIT_ADC[k];
    e.temp = INIT_TEMP[k];
    return e;
  endfunction

endpackage

FILE: sv/adclin_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the linearizer input and result streams.
// Depends on adclin_pkg for the field widths.
interface adclin_in_if import adclin_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [0:0]            cmd;
  logic [SAMPLE_BITS-1:0] sample;
  logic [PIDX_BITS-1:0]  point_index;
  logic [ADC_BITS-1:0]   point_adc;
  logic [TEMP_BITS-1:0]  point_temp;

  modport source (output valid, cmd, sample, point_index, point_adc, point_temp,
                  input ready);
  modport sink   (input valid, cmd, sample, point_index, point_adc, point_temp,
                  output ready);
endinterface

interface adclin_out_if import adclin_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TEMP_BITS-1:0] temperature;
  logic                 out_of_range;

  modport source (output valid, temperature, out_of_range, input ready);
  modport sink   (input valid, temperature, out_of_range, output ready);
endinterface

FILE: sv/adc_to_temperature_linearizer_top.sv
`timescale 1ns / 1ps
// ADC-to-temperature linearizer, top level. A conversion scans the table up to
// the first breakpoint not below the sample (one table read per cycle) and, when
// it interpolates, then multiplies and runs the serial divider before its
// result register is loaded. One transaction is in work at a time. Reset
// restores the built-in table.
module adc_to_temperature_linearizer_top import adclin_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  adclin_in_if.sink    in_i,
  adclin_out_if.source out_o
);

  // The sequencer walks the table memory, one entry per cycle. The entry for
  // index p_q arrives from the memory while the read of p_q+1 is issued, so the
  // scan never stalls on the memory latency. The previous entry is kept as the
  // lower interpolation point.
  state_e state_q, state_d;

  logic [IDX_BITS-1:0]    p_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [ADC_BITS-1:0]    prev_adc_q;
  logic [TEMP_BITS-1:0]   prev_temp_q;
  logic [TEMP_BITS-1:0]   dt_mag_q;
  logic                   dt_neg_q;
  logic [SAMPLE_BITS-1:0] dx_q;
  logic [ADC_BITS-1:0]    den_q;
  logic [NUM_BITS-1:0]    prod_q;
  logic [TEMP_BITS-1:0]   res_temp_q;
  logic                   res_oor_q;
  logic                   out_valid_q;
  logic [TEMP_BITS-1:0]   out_temp_q;
  logic                   out_oor_q;

  logic                in_fire;
  logic                is_write;
  logic                mem_we;
  logic [IDX_BITS-1:0] rd_addr;
  entry_t              wr_entry;
  entry_t              entry;
  logic                div_start;
  logic [TEMP_BITS-1:0] div_quo;
  div_status_t         div_stat;
  logic                out_free;
  logic                out_load;

  logic [CMP_BITS-1:0]  sample_ext;
  logic [CMP_BITS-1:0]  adc_ext;
  logic                 below;
  logic                 hit;
  logic [TEMP_BITS:0]   dt;
  logic [TEMP_BITS:0]   dt_abs;
  logic [CMP_BITS-1:0]  dx_full;
  logic [TEMP_BITS-1:0] q_adj;
  logic [TEMP_BITS-1:0] interp;

  assign in_fire  = in_i.valid && in_i.ready;
  assign is_write = in_i.cmd == CMD_WRITE;
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == ST_RESULT) && out_free;

  // Scan comparisons against the entry that the memory presents this cycle.
  assign sample_ext = CMP_BITS'(sample_q);
  assign adc_ext    = CMP_BITS'(entry.adc);
  assign below      = adc_ext < sample_ext;
  assign hit        = adc_ext == sample_ext;
  assign dt         = {1'b0, entry.temp} - {1'b0, prev_temp_q};
  assign dt_abs     = dt[TEMP_BITS] ? (~dt + 1'b1) : dt;
  assign dx_full    = sample_ext - CMP_BITS'(prev_adc_q);

  // A falling segment needs a ceiling on the magnitude to give a floored quotient.
  assign q_adj  = div_quo + TEMP_BITS'(dt_neg_q && div_stat.rem_nz);
  assign interp = dt_neg_q ? (prev_temp_q - q_adj) : (prev_temp_q + q_adj);

  assign wr_entry.adc  = in_i.point_adc;
  assign wr_entry.temp = in_i.point_temp;

  adclin_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (IDX_BITS'(in_i.point_index)),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (entry)
  );

  adclin_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (prod_q),
    .den_i    (den_q),
    .quo_o    (div_quo),
    .status_o (div_stat)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && !is_write) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (below) begin
          if (p_q == LAST_IDX) begin
            state_d = ST_RESULT;
          end
        end else if (hit || p_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:     state_d = ST_DIVGO;
      ST_DIVGO:   state_d = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_stat.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer. Ready is high in idle, so a valid write
  // transaction there is accepted in the same cycle.
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    rd_addr    = p_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        rd_addr    = '0;
        mem_we     = in_i.valid && is_write && (int'(in_i.point_index) < TABLE_POINTS);
      end
      ST_SCAN: begin
        rd_addr = (p_q == LAST_IDX) ? p_q : p_q + 1'b1;
      end
      ST_DIVGO: div_start = 1'b1;
      ST_MUL, ST_DIVWAIT, ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      p_q      <= '0;
      sample_q <= in_i.sample;
    end
    if (state_q == ST_SCAN) begin
      if (below) begin
        prev_adc_q  <= entry.adc;
        prev_temp_q <= entry.temp;
        res_temp_q  <= entry.temp;
        res_oor_q   <= 1'b1;
        if (p_q != LAST_IDX) begin
          p_q <= p_q + 1'b1;
        end
      end else begin
        res_temp_q <= entry.temp;
        res_oor_q  <= !hit && (p_q == '0);
        dt_neg_q   <= dt[TEMP_BITS];
        dt_mag_q   <= dt_abs[TEMP_BITS-1:0];
        dx_q       <= dx_full[SAMPLE_BITS-1:0];
        den_q      <= entry.adc - prev_adc_q;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= dt_mag_q * dx_q;
    end
    if (state_q == ST_DIVWAIT && div_stat.done) begin
      res_temp_q <= interp;
      res_oor_q  <= 1'b0;
    end
    if (out_load) begin
      out_temp_q <= res_temp_q;
      out_oor_q  <= res_oor_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.temperature  = out_temp_q;
  assign out_o.out_of_range = out_oor_q;

`ifndef SYNTHESIS
  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIVWAIT)
    else $error("divider finished outside its wait state");

  // An accepted conversion starts the table scan in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_write) |=> (state_q == ST_SCAN && p_q == '0))
    else $error("conversion did not start its scan at the first entry");

  // A finished result is never dropped while the output register still holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_valid_q && !out_o.ready) |=> state_q == ST_RESULT)
    else $error("result left its stage while the output was stalled");
`endif

endmodule

FILE: sv/adclin_mem.sv
`timescale 1ns / 1ps
// Calibration table memory: one write port, one registered read port.
// Entries never written read back as the built-in table from adclin_pkg.
module adclin_mem import adclin_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IDX_BITS-1:0] waddr_i,
  input  entry_t              wdata_i,
  input  logic [IDX_BITS-1:0] raddr_i,
  output entry_t              rdata_o
);

  entry_t                mem [TABLE_POINTS];
  logic [TABLE_POINTS-1:0] valid_q;
  entry_t                rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_BITS-1:0]   rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem[raddr_i];
    rd_addr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : init_entry(rd_addr_q);

endmodule

FILE: sv/adclin_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for the interpolation quotient, one bit per cycle.
// Depends on adclin_pkg for operand widths and the status struct.
module adclin_div import adclin_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [ADC_BITS-1:0]  den_i,
  output logic [TEMP_BITS-1:0] quo_o,
  output div_status_t          status_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [NUM_BITS-1:0]     quo_q, quo_d;
  logic [ADC_BITS-1:0]     rem_q, rem_d;
  logic [ADC_BITS-1:0]     den_q, den_d;
  logic [ADC_BITS:0]       trial;
  logic                    fits;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_BITS-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(NUM_BITS);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? ADC_BITS'(trial - {1'b0, den_q}) : ADC_BITS'(trial);
      quo_d = {quo_q[NUM_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o           = quo_q[TEMP_BITS-1:0];
  assign status_o.done   = done_q;
  assign status_o.rem_nz = rem_q != '0;

endmodule
